// ===== src/bsad_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsad_pkg - shared types and constants for the B-spline audio downsampler
// Sample, ratio and accumulator widths, register map and the fixed
// constants of the output scaling and rounding.
// ---------------------------------------------------------------------------
package bsad_pkg;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int RATIO_W    = 24;
	localparam int RATIO_FRAC = 16;
	localparam int RATIO_INT  = RATIO_W - RATIO_FRAC;
	localparam int COUNT_W    = 9;
	localparam int TAPS       = 4;

	// Ratio register, Q8.16, reset value 40.584...
	localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd2659739;
	localparam logic [RATIO_INT-1:0] RATIO_INT_MIN = 8'd2;

	// Register map
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] ADDR_RATIO = 3'd0;

	// Spline coefficient and accumulator widths (16 fraction bits in acc)
	localparam int K_W      = 21;
	localparam int ACC_W    = 38;
	localparam int ACC_FRAC = 16;

	// Output scaling: round(|acc| * 32767 / (3 * 2^32)) via shift then /3
	localparam logic [14:0] SCALE_MUL = 15'd32767;
	localparam int MAG_W   = ACC_W + 15;
	localparam int BIAS_W  = MAG_W + 1;
	localparam int DIV_SHIFT = 32;
	localparam int T_W     = BIAS_W - DIV_SHIFT;
	localparam logic [BIAS_W-1:0] ROUND_BIAS = BIAS_W'(64'd3 << 31);
	localparam logic [T_W-1:0] SAT_LIMIT = T_W'(98304);
	localparam int QT_W    = 17;
	localparam int RECIP_SHIFT = 19;
	localparam logic [17:0] RECIP_3 = 18'd174763;
	localparam int QP_W    = QT_W + 18;

	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd32768;

	// Four taps of the history, newest first
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] y2;
		logic signed [SAMPLE_W-1:0] y1;
		logic signed [SAMPLE_W-1:0] y0;
		logic signed [SAMPLE_W-1:0] ym;
	} taps_t;

	localparam int TAPS_BITS = $bits(taps_t);

endpackage

// ===== src/bsad_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsad_queue - two-entry queue between front and back
// Holds spline jobs (taps and phase) so the front can keep taking
// samples while the back is still evaluating.
// ---------------------------------------------------------------------------
module bsad_queue #(
	parameter int W = 80
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== src/bsad_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsad_front - sample intake, history and emission countdown
// Shifts each sample into the three-tap history, counts down, and on
// reaching zero queues a spline job and steps phase and countdown.
// ---------------------------------------------------------------------------
module bsad_front #(
	parameter int PHASE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  logic signed [bsad_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic [bsad_pkg::RATIO_W-1:0]           ratio,
	output logic                                   push,
	output bsad_pkg::taps_t                        push_taps,
	output logic [PHASE_BITS-1:0]                  push_phase,
	input  logic                                   full
);
	import bsad_pkg::*;

	localparam logic [RATIO_FRAC+PHASE_BITS-1:0] RST_WIDE =
		{RATIO_RESET[RATIO_FRAC-1:0], {PHASE_BITS{1'b0}}};
	localparam logic [PHASE_BITS-1:0] RST_PHASE =
		RST_WIDE[RATIO_FRAC+PHASE_BITS-1:RATIO_FRAC];
	localparam logic [COUNT_W-1:0] RST_COUNT =
		COUNT_W'(RATIO_RESET[RATIO_W-1:RATIO_FRAC]) + COUNT_W'(2);

	logic signed [SAMPLE_W-1:0]          tap_q [TAPS-1];
	logic [COUNT_W-1:0]                  count_q;
	logic [PHASE_BITS-1:0]               phase_q;
	logic                                take;
	logic [COUNT_W-1:0]                  count_dec;
	logic                                emit;
	logic [RATIO_INT-1:0]                ratio_int;
	logic [RATIO_FRAC+PHASE_BITS-1:0]    frac_wide;
	logic [PHASE_BITS-1:0]               frac_al;
	logic [PHASE_BITS:0]                 phase_sum;
	logic [COUNT_W-1:0]                  count_step;

	assign sample_ready = !full;
	assign take         = sample_valid && sample_ready;
	assign count_dec    = count_q - COUNT_W'(1);
	assign emit         = (count_dec == '0);

	// job for the back: newest sample plus the three held taps
	assign push             = take && emit;
	assign push_taps.y2     = sample_in;
	assign push_taps.y1     = tap_q[0];
	assign push_taps.y0     = tap_q[1];
	assign push_taps.ym     = tap_q[2];
	assign push_phase       = phase_q;

	// phase step: ratios below two clamp to exactly two
	always_comb begin
		frac_wide = {ratio[RATIO_FRAC-1:0], {PHASE_BITS{1'b0}}};
		if (ratio[RATIO_W-1:RATIO_FRAC] < RATIO_INT_MIN) begin
			ratio_int = RATIO_INT_MIN;
			frac_al   = '0;
		end else begin
			ratio_int = ratio[RATIO_W-1:RATIO_FRAC];
			frac_al   = frac_wide[RATIO_FRAC+PHASE_BITS-1:RATIO_FRAC];
		end
		phase_sum  = {1'b0, frac_al} + {1'b0, phase_q};
		count_step = COUNT_W'(ratio_int) + COUNT_W'(phase_sum[PHASE_BITS]);
	end

	// history shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				tap_q[i] <= '0;
			end
		end else if (take) begin
			tap_q[0] <= sample_in;
			for (int i = 1; i < TAPS - 1; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	// countdown and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RST_COUNT;
			phase_q <= RST_PHASE;
		end else if (take) begin
			if (emit) begin
				count_q <= count_step;
				phase_q <= phase_sum[PHASE_BITS-1:0];
			end else begin
				count_q <= count_dec;
			end
		end
	end
endmodule

// ===== src/bsad_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsad_back - spline evaluation and output scaling
// Horner evaluation over three multiply/add rounds, then scale by 32767,
// round half away from zero, saturate and hold in the output register.
// ---------------------------------------------------------------------------
module bsad_back #(
	parameter int PHASE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  empty,
	output logic                                  pop,
	input  bsad_pkg::taps_t                       job_taps,
	input  logic [PHASE_BITS-1:0]                 job_phase,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [bsad_pkg::SAMPLE_W-1:0]  sample_out
);
	import bsad_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_QUOT  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	localparam int PROD_W = ACC_W + PHASE_BITS + 1;

	logic [2:0]                  state_q;
	logic [1:0]                  iter_q;
	logic signed [K_W-1:0]       k0_q, k1_q, k2_q;
	logic [PHASE_BITS-1:0]       phase_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic                        neg_q;
	logic [MAG_W-1:0]            mag_q;
	logic                        sat_q;
	logic [SAMPLE_W-1:0]         quo_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  out_q;

	logic signed [K_W-1:0]       y2_e, y1_e, y0_e, ym_e;
	logic signed [K_W-1:0]       k0, k1, k2, k3, d1, d0;
	logic signed [K_W-1:0]       k_sel;
	logic signed [PROD_W-1:0]    prod_sh;
	logic [ACC_W-1:0]            mag;
	logic [BIAS_W-1:0]           biased;
	logic [T_W-1:0]              t_val;
	logic [QP_W-1:0]             q_prod;
	logic signed [SAMPLE_W-1:0]  out_val;
	logic                        out_free;

	assign result_valid = out_valid_q;
	assign sample_out   = out_q;
	assign out_free     = !out_valid_q || result_ready;
	assign pop          = (state_q == ST_IDLE) && !empty;

	// six-times spline coefficients
	always_comb begin
		y2_e = K_W'(job_taps.y2);
		y1_e = K_W'(job_taps.y1);
		y0_e = K_W'(job_taps.y0);
		ym_e = K_W'(job_taps.ym);
		d1   = y1_e - ym_e;
		d0   = y0_e - y1_e;
		k0   = ym_e + y1_e + (y0_e <<< 2);
		k1   = d1 + (d1 <<< 1);
		k2   = (ym_e + y1_e) + ((ym_e + y1_e) <<< 1) - (y0_e <<< 2) - (y0_e <<< 1);
		k3   = d0 + (d0 <<< 1) + (y2_e - ym_e);
	end

	// coefficient for the current Horner round
	always_comb begin
		case (iter_q)
			2'd0:    k_sel = k2_q;
			2'd1:    k_sel = k1_q;
			default: k_sel = k0_q;
		endcase
	end

	// floor shift, magnitude, divide by three via reciprocal
	always_comb begin
		prod_sh = prod_q >>> PHASE_BITS;
		mag     = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		biased  = {1'b0, mag_q} + ROUND_BIAS;
		t_val   = biased[BIAS_W-1:DIV_SHIFT];
		q_prod  = QP_W'(t_val[QT_W-1:0]) * QP_W'(RECIP_3);
	end

	// sign and saturation of the final value
	always_comb begin
		if (neg_q) begin
			out_val = sat_q ? OUT_MIN : $signed(SAMPLE_W'(0) - quo_q);
		end else begin
			out_val = sat_q ? OUT_MAX : $signed(quo_q);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				k0_q    <= k0;
				k1_q    <= k1;
				k2_q    <= k2;
				phase_q <= job_phase;
				acc_q   <= ACC_W'(k3) <<< ACC_FRAC;
			end
			ST_MUL: begin
				prod_q <= acc_q * $signed({1'b0, phase_q});
			end
			ST_ADD: begin
				acc_q <= ACC_W'(prod_sh) + (ACC_W'(k_sel) <<< ACC_FRAC);
			end
			ST_SCALE: begin
				neg_q <= acc_q[ACC_W-1];
				mag_q <= MAG_W'(mag) * MAG_W'(SCALE_MUL);
			end
			ST_QUOT: begin
				sat_q <= (t_val >= SAT_LIMIT);
				quo_q <= SAMPLE_W'(q_prod >> RECIP_SHIFT);
			end
			default: begin
				if (out_free) begin
					out_q <= out_val;
				end
			end
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						iter_q  <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					iter_q  <= iter_q + 2'd1;
					state_q <= (iter_q == 2'd2) ? ST_SCALE : ST_MUL;
				end
				ST_SCALE: begin
					state_q <= ST_QUOT;
				end
				ST_QUOT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== src/bspline_audio_downsampler.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bspline_audio_downsampler - cubic B-spline 4-point audio downsampler
// Decimates a Q1.15 sample stream by a Q8.16 ratio, evaluating a
// third-order B-spline over the last four samples at each output point.
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_ready    sample_in
//   result    out        result_valid / result_ready    sample_out
//   config    in         APB psel/penable/pwrite        paddr, pwdata, prdata
//
// A sample is taken on a valid/ready handshake; the history and countdown update at once.
// Each result passes through the back in order: job load, three multiply/add
// rounds of the shared Horner multiplier, two scaling steps, output load.
// A two-entry job queue sits between front and back; the front stalls
// whenever the queue is full.
// Reset clears history, restores the ratio and its countdown and phase.
// ---------------------------------------------------------------------------
module bspline_audio_downsampler #(
	parameter int PHASE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [bsad_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [bsad_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [bsad_pkg::ADDR_W-1:0]           paddr,
	input  logic [bsad_pkg::DATA_W-1:0]           pwdata,
	output logic [bsad_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);
	import bsad_pkg::*;

	localparam int QW = TAPS_BITS + PHASE_BITS;

	logic [RATIO_W-1:0]     ratio_q;
	logic                   push;
	taps_t                  push_taps;
	logic [PHASE_BITS-1:0]  push_phase;
	logic                   full;
	logic                   pop;
	logic                   empty;
	logic [QW-1:0]          pop_data;
	taps_t                  job_taps;
	logic [PHASE_BITS-1:0]  job_phase;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_RATIO) ? DATA_W'(ratio_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_RATIO)) begin
			ratio_q <= pwdata[RATIO_W-1:0];
		end
	end

	// intake and countdown
	bsad_front #(
		.PHASE_BITS (PHASE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_in    (sample_in),
		.ratio        (ratio_q),
		.push         (push),
		.push_taps    (push_taps),
		.push_phase   (push_phase),
		.full         (full)
	);

	// job queue
	bsad_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_taps, push_phase}),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	assign job_taps  = pop_data[QW-1:PHASE_BITS];
	assign job_phase = pop_data[PHASE_BITS-1:0];

	// spline evaluation
	bsad_back #(
		.PHASE_BITS (PHASE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop          (pop),
		.job_taps     (job_taps),
		.job_phase    (job_phase),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample_out   (sample_out)
	);
endmodule
